// ----- src/dfr_pkg.sv -----
// ---------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the frame difference block
// Geometry limits, register indexes, pattern words and the structs that
// pass word position and box results between modules.
// ---------------------------------------------------------------------------
package dfr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_WORDS  = 262144;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = COL_W + 1;
    localparam int HEIGHT_W = ROW_W + 1;
    localparam int ADDR_W   = $clog2(MAX_WORDS);
    localparam int PROD_W   = ROW_W + COL_W;

    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WIDTH_W;

    localparam int WORD_W    = 32;
    localparam int PIX_W     = 16;
    localparam int CH_W      = 5;
    localparam int OUT_PIX_W = 3 * CH_W;
    localparam int CONV_W    = PIX_W + OUT_PIX_W;

    localparam int IN_TDATA_W  = WORD_W;
    localparam int OUT_FIELD_W = ADDR_W + CONV_W + 2 + COL_W + ROW_W + WIDTH_W + HEIGHT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_RED_SHIFT    = 3'd2,
        CFG_GREEN_SHIFT  = 3'd3,
        CFG_BLUE_SHIFT   = 3'd4
    } t_cfg_idx;

    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = WIDTH_W'(320);
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = HEIGHT_W'(480);
    localparam logic [SHIFT_W-1:0]  RST_RED_SHIFT    = 4'd11;
    localparam logic [SHIFT_W-1:0]  RST_GREEN_SHIFT  = 4'd6;
    localparam logic [SHIFT_W-1:0]  RST_BLUE_SHIFT   = 4'd0;

    localparam logic [WORD_W-1:0] CHECKER_A = 32'h18e3_20e4;
    localparam logic [WORD_W-1:0] CHECKER_B = 32'h20e4_18e3;
    localparam logic [WORD_W-1:0] FLAT_WORD = 32'h18e3_18e3;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_end;
    } t_pos;

    typedef struct packed {
        logic                any_dirty;
        logic [COL_W-1:0]    left;
        logic [ROW_W-1:0]    top;
        logic [WIDTH_W-1:0]  right;
        logic [HEIGHT_W-1:0] bottom;
    } t_rect;

endpackage

// ----- src/dfr_ram.sv -----
// ---------------------------------------------------------------------------
// dfr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ---------------------------------------------------------------------------
module dfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/dfr_lane.sv -----
// ---------------------------------------------------------------------------
// dfr_lane: one pixel lane
// Compares one 16-bit half against the stored half and extracts the three
// 5-bit channels of that half with the configured shifts.
// ---------------------------------------------------------------------------
module dfr_lane (
    input  logic [dfr_pkg::WORD_W-1:0]    i_src,
    input  logic [dfr_pkg::SHIFT_W-1:0]   i_red_shift,
    input  logic [dfr_pkg::SHIFT_W-1:0]   i_green_shift,
    input  logic [dfr_pkg::SHIFT_W-1:0]   i_blue_shift,
    input  logic [dfr_pkg::PIX_W-1:0]     i_old_half,
    input  logic [dfr_pkg::PIX_W-1:0]     i_new_half,
    output logic [dfr_pkg::OUT_PIX_W-1:0] o_pixel,
    output logic                          o_diff
);
    import dfr_pkg::*;

    logic [WORD_W-1:0] w_red;
    logic [WORD_W-1:0] w_green;
    logic [WORD_W-1:0] w_blue;

    // source arrives pre-aligned so this lane's half sits at bit zero
    assign w_red   = i_src >> i_red_shift;
    assign w_green = i_src >> i_green_shift;
    assign w_blue  = i_src >> i_blue_shift;

    assign o_pixel = {w_blue[CH_W-1:0], w_green[CH_W-1:0], w_red[CH_W-1:0]};
    assign o_diff  = (i_old_half != i_new_half);

endmodule

// ----- src/dfr_box.sv -----
// ---------------------------------------------------------------------------
// dfr_box: dirty rectangle merge
// Merges the lanes' change flag into a bounding box of changed words and
// reports the box on the last word of a frame.
// ---------------------------------------------------------------------------
module dfr_box (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_changed,
    input  dfr_pkg::t_pos  i_pos,
    output dfr_pkg::t_rect o_rect
);
    import dfr_pkg::*;

    logic [COL_W-1:0] r_min_x, r_max_x, n_min_x, n_max_x;
    logic [ROW_W-1:0] r_min_y, r_max_y, n_min_y, n_max_y;
    logic             r_seen, n_seen;
    logic             w_report;

    always_comb begin
        n_min_x = r_min_x;
        n_max_x = r_max_x;
        n_min_y = r_min_y;
        n_max_y = r_max_y;
        if (i_changed) begin
            if (i_pos.col < r_min_x) begin
                n_min_x = i_pos.col;
            end
            if (i_pos.col > r_max_x) begin
                n_max_x = i_pos.col;
            end
            if (i_pos.row < r_min_y) begin
                n_min_y = i_pos.row;
            end
            if (i_pos.row > r_max_y) begin
                n_max_y = i_pos.row;
            end
        end
        n_seen = r_seen | i_changed;
    end

    assign w_report = i_pos.frame_end && n_seen;

    always_comb begin
        o_rect.any_dirty = w_report;
        o_rect.left      = w_report ? n_min_x : '0;
        o_rect.top       = w_report ? n_min_y : '0;
        o_rect.right     = w_report ? (WIDTH_W'(n_max_x) + WIDTH_W'(2)) : '0;
        o_rect.bottom    = w_report ? (HEIGHT_W'(n_max_y) + HEIGHT_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '1;
            r_max_x <= '0;
            r_min_y <= '1;
            r_max_y <= '0;
            r_seen  <= 1'b0;
        end else if (i_adv) begin
            if (i_pos.frame_end) begin
                // restart the box for the next frame
                r_min_x <= '1;
                r_max_x <= '0;
                r_min_y <= '1;
                r_max_y <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_min_x <= n_min_x;
                r_max_x <= n_max_x;
                r_min_y <= n_min_y;
                r_max_y <= n_max_y;
                r_seen  <= n_seen;
            end
        end
    end

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_min_x <= r_max_x) && (r_min_y <= r_max_y))
        else $error("box min exceeds max after a change");

    a_clean_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_min_x == '1) && (r_max_x == '0) && (r_min_y == '1))
        else $error("box moved without a change");

endmodule

// ----- src/frame_diff_dirty_rect_top.sv -----
// ---------------------------------------------------------------------------
// frame_diff_dirty_rect_top: frame change detector with dirty rectangle
// Compares each pixel-pair word with the stored previous frame, stores
// changed words, converts pixels to 5-5-5 and reports the bounding box of
// changed words on the last word of every frame.
//
//  Channel  Dir  Handshake             Payload
//  s_axis   in   tvalid/tready         tdata[31:0] pixel_pair
//  m_axis   out  tvalid/tready         tdata word/pixels/box, tlast frame_end
//  cfg      in   i_cfg_wr_en           i_cfg_index, i_cfg_wdata
//
// One word per cycle while m_axis does not stall; a word is registered in
// stage 1 and then in the output register before it shows on m_axis. The
// limit is the previous-frame RAM: one read and one write port.
// After reset a clearing pass writes zero to all 262144 RAM words, one per
// cycle, and s_axis_tready stays low until the pass is done.
// A stall on m_axis holds the pipeline and drops s_axis_tready once stage 1 holds a word.
// ---------------------------------------------------------------------------
module frame_diff_dirty_rect_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_wr_en,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] pixel_pair
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [17:0] word_index, [48:18] converted_pair, [49] changed, [50] any_dirty,
    // [60:51] rect_left, [69:61] rect_top, [80:70] rect_right,
    // [90:81] rect_bottom, [95:91] zero
    output logic [dfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast   // frame_end
);
    import dfr_pkg::*;

    // configuration
    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [SHIFT_W-1:0]  r_red_shift, r_green_shift, r_blue_shift;

    // position counters
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // RAM clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // stage 1: RAM read in flight
    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    t_pos              r_s1_pos;
    logic              r_s1_fwd;
    logic [WORD_W-1:0] r_s1_fwd_data;

    // output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_index;
    logic [CONV_W-1:0] r_out_conv;
    logic              r_out_changed;
    logic              r_out_last;
    t_rect             r_out_rect;

    logic [WIDTH_W-1:0]  w_width;
    logic [HEIGHT_W-1:0] w_height;
    logic [COL_W-1:0]    w_words_per_line;
    logic [PROD_W-1:0]   w_prod;
    logic [ADDR_W-1:0]   w_widx;
    logic                w_line_end, w_frame_end;
    logic                w_accept, w_s1_adv;
    logic [WORD_W-1:0]   w_old, w_ram_rdata, w_fixed;
    logic [OUT_PIX_W-1:0] w_pix_lo, w_pix_hi;
    logic                w_diff_lo, w_diff_hi, w_changed;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic [WORD_W-1:0]   w_ram_wdata;
    t_pos                w_pos;
    t_rect               w_rect;

    // geometry, saturated
    always_comb begin
        if (r_frame_width < WIDTH_W'(2)) begin
            w_width = WIDTH_W'(2);
        end else if (r_frame_width > WIDTH_W'(MAX_WIDTH)) begin
            w_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_width = r_frame_width;
        end
        if (r_frame_height < HEIGHT_W'(1)) begin
            w_height = HEIGHT_W'(1);
        end else if (r_frame_height > HEIGHT_W'(MAX_HEIGHT)) begin
            w_height = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            w_height = r_frame_height;
        end
    end

    assign w_words_per_line = COL_W'((w_width + WIDTH_W'(1)) >> 1);
    assign w_prod = PROD_W'(r_row) * PROD_W'(w_words_per_line);
    assign w_widx = ADDR_W'(w_prod + PROD_W'(r_col >> 1));

    assign w_line_end  = (WIDTH_W'(r_col) + WIDTH_W'(2)) >= w_width;
    assign w_frame_end = w_line_end && ((HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= w_height);

    always_comb begin
        if (w_frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (w_line_end) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(2);
            n_row = r_row;
        end
    end

    // handshakes
    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || w_s1_adv);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // a same-address write leaving stage 1 is newer than the RAM read
    assign w_old   = r_s1_fwd ? r_s1_fwd_data : w_ram_rdata;
    assign w_fixed = ((r_s1_pix == CHECKER_A) || (r_s1_pix == CHECKER_B)) ? FLAT_WORD
                                                                          : r_s1_pix;

    dfr_lane u_lane_lo (
        .i_src         (w_fixed),
        .i_red_shift   (r_red_shift),
        .i_green_shift (r_green_shift),
        .i_blue_shift  (r_blue_shift),
        .i_old_half    (w_old[PIX_W-1:0]),
        .i_new_half    (r_s1_pix[PIX_W-1:0]),
        .o_pixel       (w_pix_lo),
        .o_diff        (w_diff_lo)
    );

    dfr_lane u_lane_hi (
        .i_src         (w_fixed >> PIX_W),
        .i_red_shift   (r_red_shift),
        .i_green_shift (r_green_shift),
        .i_blue_shift  (r_blue_shift),
        .i_old_half    (w_old[WORD_W-1:PIX_W]),
        .i_new_half    (r_s1_pix[WORD_W-1:PIX_W]),
        .o_pixel       (w_pix_hi),
        .o_diff        (w_diff_hi)
    );

    assign w_changed = w_diff_lo | w_diff_hi;

    dfr_box u_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_s1_adv),
        .i_changed (w_changed),
        .i_pos     (r_s1_pos),
        .o_rect    (w_rect)
    );

    // RAM write: clearing pass first, then changed words
    assign w_ram_we    = r_clr_busy || (w_s1_adv && w_changed);
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign w_ram_wdata = r_clr_busy ? '0 : r_s1_pix;

    dfr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_prev_frame (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_widx),
        .o_rd_data (w_ram_rdata)
    );

    always_comb begin
        w_pos.col       = r_col;
        w_pos.row       = r_row;
        w_pos.frame_end = w_frame_end;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_red_shift    <= RST_RED_SHIFT;
            r_green_shift  <= RST_GREEN_SHIFT;
            r_blue_shift   <= RST_BLUE_SHIFT;
            r_col          <= '0;
            r_row          <= '0;
            r_clr_busy     <= 1'b1;
            r_clr_addr     <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[WIDTH_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[HEIGHT_W-1:0];
                    CFG_RED_SHIFT:    r_red_shift    <= i_cfg_wdata[SHIFT_W-1:0];
                    CFG_GREEN_SHIFT:  r_green_shift  <= i_cfg_wdata[SHIFT_W-1:0];
                    CFG_BLUE_SHIFT:   r_blue_shift   <= i_cfg_wdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MAX_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix      <= s_axis_tdata[WORD_W-1:0];
            r_s1_addr     <= w_widx;
            r_s1_pos      <= w_pos;
            r_s1_fwd      <= r_s1_valid && (r_s1_addr == w_widx);
            r_s1_fwd_data <= r_s1_pix;
        end
        if (w_s1_adv) begin
            r_out_index   <= r_s1_addr;
            r_out_conv    <= {w_pix_hi, 1'b0, w_pix_lo};
            r_out_changed <= w_changed;
            r_out_last    <= r_s1_pos.frame_end;
            r_out_rect    <= w_rect;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_rect.bottom, r_out_rect.right,
                            r_out_rect.top, r_out_rect.left, r_out_rect.any_dirty,
                            r_out_changed, r_out_conv, r_out_index};

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready && !r_s1_valid)
        else $error("word in flight during clearing pass");

    a_dirty_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rect.any_dirty) |->
            r_out_last && (WIDTH_W'(r_out_rect.left) < r_out_rect.right) &&
            (HEIGHT_W'(r_out_rect.top) < r_out_rect.bottom))
        else $error("box reported off frame end or inverted");

    a_fwd_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_s1_valid |-> w_s1_adv)
        else $error("new word taken while stage 1 held");

endmodule

// ----- bench/frame_diff_dirty_rect_top_tb.sv -----
// ---------------------------------------------------------------------------
// frame_diff_dirty_rect_top_tb: self-checking bench for the frame change
// detector
// Streams pixel-pair words through the block under a range of geometries
// and channel shifts. A local predictor keeps its own copy of the previous
// frame, scan position and dirty box, and every output transfer is checked
// against the oldest expected result. A short directed table comes first,
// then random phases under new geometries with a varying share of changed words.
// ---------------------------------------------------------------------------
module frame_diff_dirty_rect_top_tb;

    import dfr_pkg::*;

    localparam int          RANDOM_WORDS   = 1150;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          DRAIN_LIMIT    = 50000;
    localparam int          MAX_REPORTS    = 10;
    localparam int          TIMEOUT_UNITS  = 3000000;
    localparam int          DRILL_ROWS     = 34;
    localparam logic [31:0] CHANNEL_MASK   = 32'h001f_001f;

    // register indexes past the end of the map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]   word_index;
        logic [CONV_W-1:0]   pixels;
        logic                changed;
        logic                frame_end;
        logic                any_dirty;
        logic [COL_W-1:0]    left;
        logic [ROW_W-1:0]    top;
        logic [WIDTH_W-1:0]  right;
        logic [HEIGHT_W-1:0] bottom;
    } t_pair_result;

    typedef enum bit {STEP_WORD, STEP_CFG} t_step_kind;

    typedef struct {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    value;
        bit                   typed;
        t_pair_result         want;
    } t_drill_step;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_TOGGLE, SINK_SPARSE} t_sink_mode;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    frame_diff_dirty_rect_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---- predictor state: registers, scan position, dirty box, frame copy ----
    logic [WIDTH_W-1:0]  geo_width  = RST_FRAME_WIDTH;
    logic [HEIGHT_W-1:0] geo_height = RST_FRAME_HEIGHT;
    logic [SHIFT_W-1:0]  sh_red     = RST_RED_SHIFT;
    logic [SHIFT_W-1:0]  sh_green   = RST_GREEN_SHIFT;
    logic [SHIFT_W-1:0]  sh_blue    = RST_BLUE_SHIFT;

    logic [COL_W-1:0] scan_col = '0;
    logic [ROW_W-1:0] scan_row = '0;
    logic [COL_W-1:0] box_x0   = '1;
    logic [COL_W-1:0] box_x1   = '0;
    logic [ROW_W-1:0] box_y0   = '1;
    logic [ROW_W-1:0] box_y1   = '0;
    logic             box_hit  = 1'b0;

    logic [WORD_W-1:0] frame_store [int unsigned];

    t_pair_result pending_pairs [$];
    int           mismatch_count = 0;
    int           burst_left     = 0;

    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_span = 0;

    t_drill_step drill [DRILL_ROWS] = '{
        '{STEP_WORD, '0, 32'h0000_0000, 1'b1, '{default: '0}},
        '{STEP_WORD, '0, 32'hffff_ffff, 1'b1,
          '{word_index: 18'd1, pixels: 31'h7fff_7fff, changed: 1'b1, default: '0}},
        // shrink the geometry while the scan is past the new line end
        '{STEP_CFG,  CFG_FRAME_WIDTH,  32'd4,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_FRAME_HEIGHT, 32'd2,   1'b0, '{default: '0}},
        '{STEP_WORD, '0, CHECKER_A,      1'b0, '{default: '0}},
        '{STEP_WORD, '0, CHECKER_B,      1'b0, '{default: '0}},
        // zero width and height saturate to a one-word frame
        '{STEP_CFG,  CFG_FRAME_WIDTH,  32'd0,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_FRAME_HEIGHT, 32'd0,   1'b0, '{default: '0}},
        '{STEP_WORD, '0, FLAT_WORD,      1'b0, '{default: '0}},
        '{STEP_WORD, '0, FLAT_WORD,      1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_RED_SHIFT,    32'd15,  1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_GREEN_SHIFT,  32'd15,  1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_BLUE_SHIFT,   32'd15,  1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'hffff_ffff,  1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_SPARE_LO,     32'h7ff, 1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_SPARE_HI,     32'd3,   1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'h0000_0001,  1'b0, '{default: '0}},
        // oversize geometry saturates to the maximum frame
        '{STEP_CFG,  CFG_FRAME_WIDTH,  32'd2047, 1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_FRAME_HEIGHT, 32'd1023, 1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_RED_SHIFT,    32'd0,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_GREEN_SHIFT,  32'd0,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_BLUE_SHIFT,   32'd0,   1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'h5555_aaaa,  1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'haaaa_5555,  1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'h8000_0001,  1'b0, '{default: '0}},
        // odd width: last word of a line hangs one pixel past it
        '{STEP_CFG,  CFG_FRAME_WIDTH,  32'd3,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_FRAME_HEIGHT, 32'd2,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_RED_SHIFT,    32'd11,  1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_GREEN_SHIFT,  32'd6,   1'b0, '{default: '0}},
        '{STEP_CFG,  CFG_BLUE_SHIFT,   32'd0,   1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'h1234_5678,  1'b0, '{default: '0}},
        '{STEP_WORD, '0, CHECKER_A,      1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'hffff_ffff,  1'b0, '{default: '0}},
        '{STEP_WORD, '0, 32'h0001_0000,  1'b0, '{default: '0}}
    };

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(geo_width);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(geo_height);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic int unsigned scan_addr();
        return (32'(scan_row) * ((eff_width() + 1) >> 1) + (32'(scan_col) >> 1)) % MAX_WORDS;
    endfunction

    function automatic logic [WORD_W-1:0] stored_word(input int unsigned addr);
        return frame_store.exists(addr) ? frame_store[addr] : '0;
    endfunction

    function automatic logic [WORD_W-1:0] pack_rgb555(input logic [WORD_W-1:0] p);
        logic [WORD_W-1:0] r, g, b;
        r = (p >> sh_red) & CHANNEL_MASK;
        g = (p >> sh_green) & CHANNEL_MASK;
        b = (p >> sh_blue) & CHANNEL_MASK;
        return r | (g << 5) | (b << 10);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_FRAME_WIDTH:  geo_width  = data;
            CFG_FRAME_HEIGHT: geo_height = data[HEIGHT_W-1:0];
            CFG_RED_SHIFT:    sh_red     = data[SHIFT_W-1:0];
            CFG_GREEN_SHIFT:  sh_green   = data[SHIFT_W-1:0];
            CFG_BLUE_SHIFT:   sh_blue    = data[SHIFT_W-1:0];
            default: ;
        endcase
    endfunction

    // Compare against the stored frame, grow the box and advance the scan.
    function automatic t_pair_result predict_pair(input logic [WORD_W-1:0] pix);
        int unsigned  w, h, addr;
        logic         line_end;
        t_pair_result r;
        w    = eff_width();
        h    = eff_height();
        addr = scan_addr();
        r    = '0;
        r.word_index = ADDR_W'(addr);
        r.changed    = stored_word(addr) != pix;
        if (r.changed) begin
            frame_store[addr] = pix;
            if (scan_col < box_x0) box_x0 = scan_col;
            if (scan_col > box_x1) box_x1 = scan_col;
            if (scan_row < box_y0) box_y0 = scan_row;
            if (scan_row > box_y1) box_y1 = scan_row;
            box_hit = 1'b1;
        end
        r.pixels = CONV_W'(pack_rgb555((pix == CHECKER_A || pix == CHECKER_B) ? FLAT_WORD : pix));
        line_end    = 32'(scan_col) + 2 >= w;
        r.frame_end = line_end && (32'(scan_row) + 1 >= h);
        if (r.frame_end) begin
            if (box_hit) begin
                r.any_dirty = 1'b1;
                r.left      = box_x0;
                r.top       = box_y0;
                r.right     = WIDTH_W'(32'(box_x1) + 2);
                r.bottom    = HEIGHT_W'(32'(box_y1) + 1);
            end
            box_x0   = '1;
            box_x1   = '0;
            box_y0   = '1;
            box_y1   = '0;
            box_hit  = 1'b0;
            scan_col = '0;
            scan_row = '0;
        end else if (line_end) begin
            scan_col = '0;
            scan_row = scan_row + 1'b1;
        end else begin
            scan_col = scan_col + 10'd2;
        end
        return r;
    endfunction

    // One transfer on the input stream; bursts end in a random gap.
    task automatic send_word(input logic [WORD_W-1:0] word, input bit typed,
                             input t_pair_result want);
        int gap;
        t_pair_result r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_pair(word);
        pending_pairs.push_back(typed ? want : r);
    endtask

    // Hold the input until every expected result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_register(index, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver backpressure: a mode held for a random span of cycles
    always @(posedge i_clk) begin
        if (sink_span == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_span <= $urandom_range(20, 120);
        end else begin
            sink_span <= sink_span - 1;
        end
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_COIN:   m_axis_tready <= $urandom_range(0, 3) != 0;
            SINK_TOGGLE: m_axis_tready <= ~m_axis_tready;
            default:     m_axis_tready <= $urandom_range(0, 7) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        t_pair_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.word_index = m_axis_tdata[17:0];
            got.pixels     = m_axis_tdata[48:18];
            got.changed    = m_axis_tdata[49];
            got.frame_end  = m_axis_tlast;
            got.any_dirty  = m_axis_tdata[50];
            got.left       = m_axis_tdata[60:51];
            got.top        = m_axis_tdata[69:61];
            got.right      = m_axis_tdata[80:70];
            got.bottom     = m_axis_tdata[90:81];
            if (pending_pairs.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: idx=%0d pixels=%h", got.word_index, got.pixels);
                mismatch_count++;
            end else begin
                want = pending_pairs.pop_front();
                if (got != want) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"mismatch idx/pixels/chg/end/dirty/l/t/r/b: ",
                                  "exp %0d %h %b %b %b %0d %0d %0d %0d, ",
                                  "got %0d %h %b %b %b %0d %0d %0d %0d"},
                                 want.word_index, want.pixels, want.changed,
                                 want.frame_end, want.any_dirty, want.left, want.top,
                                 want.right, want.bottom,
                                 got.word_index, got.pixels, got.changed,
                                 got.frame_end, got.any_dirty, got.left, got.top,
                                 got.right, got.bottom);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int                    random_words;
        int                    span;
        int                    change_pct;
        int                    drain_cycles;
        logic [WORD_W-1:0]     word;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] height_val;
        bit                    wide_phase;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (drill[i]) begin
            if (drill[i].kind == STEP_CFG) begin
                drain_results();
                cfg_write(drill[i].index, drill[i].value[CFG_DATA_W-1:0]);
            end else begin
                send_word(drill[i].value, drill[i].typed, drill[i].want);
            end
        end

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            drain_results();
            wide_phase = 1'b0;
            case ($urandom_range(0, 9))
                0: begin
                    // any register value, saturation included; leave mid-frame
                    width_val  = CFG_DATA_W'($urandom_range(0, 2047));
                    height_val = CFG_DATA_W'($urandom_range(0, 1023));
                    wide_phase = 1'b1;
                end
                1: begin
                    width_val  = CFG_DATA_W'(2 * $urandom_range(1, 12) + 1);
                    height_val = CFG_DATA_W'($urandom_range(1, 6));
                end
                default: begin
                    width_val  = CFG_DATA_W'(2 * $urandom_range(1, 12));
                    height_val = CFG_DATA_W'($urandom_range(1, 6));
                end
            endcase
            cfg_write(CFG_FRAME_WIDTH, width_val);
            cfg_write(CFG_FRAME_HEIGHT, height_val);
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(CFG_RED_SHIFT, CFG_DATA_W'($urandom_range(0, 2047)));
                cfg_write(CFG_GREEN_SHIFT, CFG_DATA_W'($urandom_range(0, 2047)));
                cfg_write(CFG_BLUE_SHIFT, CFG_DATA_W'($urandom_range(0, 2047)));
            end
            if ($urandom_range(0, 9) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          CFG_DATA_W'($urandom_range(0, 2047)));

            if (wide_phase) begin
                span = $urandom_range(10, 40);
            end else begin
                span = ((eff_width() + 1) >> 1) * eff_height() * $urandom_range(1, 4);
                if (span > 150) span = 150;
            end
            case ($urandom_range(0, 3))
                0:       change_pct = 0;
                1:       change_pct = 5;
                2:       change_pct = 30;
                default: change_pct = 100;
            endcase

            repeat (span) begin
                if ($urandom_range(0, 99) >= change_pct) begin
                    word = stored_word(scan_addr());
                end else begin
                    case ($urandom_range(0, 9))
                        0:       word = CHECKER_A;
                        1:       word = CHECKER_B;
                        2:       word = FLAT_WORD;
                        3:       word = '0;
                        4:       word = '1;
                        default: word = $urandom;
                    endcase
                end
                send_word(word, 1'b0, '0);
                random_words++;
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_pairs.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_pairs.size() != 0) begin
            $display("%0d expected results never arrived", pending_pairs.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // covers the clearing pass after reset plus the slowest handshakes
    initial begin
        #(TIMEOUT_UNITS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/dfr_pkg.sv
src/dfr_ram.sv
src/dfr_lane.sv
src/dfr_box.sv
src/frame_diff_dirty_rect_top.sv
bench/frame_diff_dirty_rect_top_tb.sv
